[sv/krd_pkg.sv]
// Shared types and constants for the kernel response deframer.
`default_nettype none
package krd_pkg;

  // Frame marker bytes
  localparam logic [7:0] PREAMBLE1 = 8'hBE;
  localparam logic [7:0] PREAMBLE2 = 8'hEF;

  // Register reset value
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_PRE1    = 3'd0;
  localparam logic [2:0] ERR_PRE2    = 3'd1;
  localparam logic [2:0] ERR_ZEROLEN = 3'd2;
  localparam logic [2:0] ERR_BIG     = 3'd3;
  localparam logic [2:0] ERR_SUM     = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT = 3'd5;

  // Receive phase, one-hot
  typedef enum logic [6:0] {
    PH_PRE1 = 7'b0000001,
    PH_PRE2 = 7'b0000010,
    PH_LENH = 7'b0000100,
    PH_LENL = 7'b0001000,
    PH_ID   = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_SUM  = 7'b1000000
  } phase_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  response_id;
    logic [15:0] payload_length;
    logic [2:0]  error_code;
  } result_t;

endpackage
`default_nettype wire

[sv/kernel_response_deframer.sv]
// Kernel response deframer: byte-stream frame parser with output skid stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: a received
//   byte (in_req_type = 0, in_rx_byte) or a read timeout (in_req_type = 1).
//   Output channel (out_valid/out_ready) carries at most one result per input
//   beat: a payload byte, a frame accept with ID and length, or an error code.
//   Payload bytes stream out before the checksum is known; a consumer drops
//   them when an error result follows.
//   cfg_we/cfg_wdata write max_payload; write it only while the block is idle.
// Timing:
//   Each input beat is parsed in the cycle it is accepted; its result, if any,
//   is registered in the output register, or in the skid register on a stall.
//   Throughput is one beat per cycle while in_ready is high (phase/checksum update).
// Reset (rst_n low, synchronous): parser returns to hunting for the first
//   preamble, checksum clears, max_payload returns to 256, no results pending.
// Stall: while out_ready is low one more result is held in a skid register;
//   once it is occupied in_ready drops until the output drains.
`default_nettype none
module kernel_response_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_response_id,
  output logic [15:0]      out_payload_length,
  output logic [2:0]       out_error_code,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  krd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic [15:0]      frame_length_r, frame_length_nxt;
  logic [15:0]      bytes_left_r, bytes_left_nxt;
  logic [7:0]       held_id_r, held_id_nxt;
  logic [15:0]      max_payload_r;

  logic             in_fire;
  logic             res_fire;
  krd_pkg::result_t res;
  logic [7:0]       sum_add;
  logic [15:0]      len_full;

  logic             out_valid_r;
  krd_pkg::result_t out_r;
  logic             skid_valid_r;
  krd_pkg::result_t skid_r;
  logic             out_free;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign sum_add  = 8'(running_sum_r + in_rx_byte);
  assign len_full = {frame_length_r[15:8], in_rx_byte};

  // Parse one event: next phase, checksum, counters and result
  always_comb begin
    phase_nxt        = phase_r;
    running_sum_nxt  = running_sum_r;
    frame_length_nxt = frame_length_r;
    bytes_left_nxt   = bytes_left_r;
    held_id_nxt      = held_id_r;
    res_fire         = 1'b0;
    res              = '0;
    if (in_req_type) begin
      phase_nxt      = krd_pkg::PH_PRE1;
      res_fire       = 1'b1;
      res.kind       = krd_pkg::KIND_ERR;
      res.error_code = krd_pkg::ERR_TIMEOUT;
    end else begin
      unique case (phase_r)
        krd_pkg::PH_PRE2: begin
          if (in_rx_byte != krd_pkg::PREAMBLE2) begin
            phase_nxt      = krd_pkg::PH_PRE1;
            res_fire       = 1'b1;
            res.kind       = krd_pkg::KIND_ERR;
            res.error_code = krd_pkg::ERR_PRE2;
          end else begin
            running_sum_nxt = sum_add;
            phase_nxt       = krd_pkg::PH_LENH;
          end
        end
        krd_pkg::PH_LENH: begin
          frame_length_nxt = {in_rx_byte, 8'h00};
          running_sum_nxt  = sum_add;
          phase_nxt        = krd_pkg::PH_LENL;
        end
        krd_pkg::PH_LENL: begin
          running_sum_nxt = sum_add;
          if (len_full == 16'd0) begin
            frame_length_nxt = len_full;
            phase_nxt        = krd_pkg::PH_PRE1;
            res_fire         = 1'b1;
            res.kind         = krd_pkg::KIND_ERR;
            res.error_code   = krd_pkg::ERR_ZEROLEN;
          end else begin
            // store the payload count, length field minus the ID byte
            frame_length_nxt = len_full - 16'd1;
            phase_nxt        = krd_pkg::PH_ID;
          end
        end
        krd_pkg::PH_ID: begin
          held_id_nxt     = in_rx_byte;
          running_sum_nxt = sum_add;
          if (frame_length_r > max_payload_r) begin
            phase_nxt      = krd_pkg::PH_PRE1;
            res_fire       = 1'b1;
            res.kind       = krd_pkg::KIND_ERR;
            res.error_code = krd_pkg::ERR_BIG;
          end else begin
            bytes_left_nxt = frame_length_r;
            phase_nxt      = (frame_length_r == 16'd0) ? krd_pkg::PH_SUM : krd_pkg::PH_DATA;
          end
        end
        krd_pkg::PH_DATA: begin
          running_sum_nxt  = sum_add;
          bytes_left_nxt   = bytes_left_r - 16'd1;
          if (bytes_left_r == 16'd1) begin
            phase_nxt = krd_pkg::PH_SUM;
          end
          res_fire         = 1'b1;
          res.kind         = krd_pkg::KIND_DATA;
          res.payload_byte = in_rx_byte;
        end
        krd_pkg::PH_SUM: begin
          phase_nxt = krd_pkg::PH_PRE1;
          res_fire  = 1'b1;
          if (in_rx_byte != running_sum_r) begin
            res.kind       = krd_pkg::KIND_ERR;
            res.error_code = krd_pkg::ERR_SUM;
          end else begin
            res.kind           = krd_pkg::KIND_OK;
            res.response_id    = held_id_r;
            res.payload_length = frame_length_r;
          end
        end
        default: begin
          // hunt for the first preamble byte
          if (in_rx_byte != krd_pkg::PREAMBLE1) begin
            phase_nxt      = krd_pkg::PH_PRE1;
            res_fire       = 1'b1;
            res.kind       = krd_pkg::KIND_ERR;
            res.error_code = krd_pkg::ERR_PRE1;
          end else begin
            running_sum_nxt = krd_pkg::PREAMBLE1;
            phase_nxt       = krd_pkg::PH_PRE2;
          end
        end
      endcase
    end
  end

  // Advance parser state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= krd_pkg::PH_PRE1;
      running_sum_r  <= 8'd0;
      frame_length_r <= 16'd0;
      bytes_left_r   <= 16'd0;
      held_id_r      <= 8'd0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      running_sum_r  <= running_sum_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      held_id_r      <= held_id_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= krd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  // Output register and skid stage: hold on stall, drain skid first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && res_fire;
      end
    end else if (in_fire && res_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && !skid_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_response_id    = out_r.response_id;
  assign out_payload_length = out_r.payload_length;
  assign out_error_code     = out_r.error_code;

`ifndef ASSERT_OFF
  // skid only fills behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  // a pending skid beat moves to the output once the receiver takes one
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid beat not drained");

  // payload results only come from the payload phase
  a_data_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_fire && (res.kind == krd_pkg::KIND_DATA)
      |-> (phase_r == krd_pkg::PH_DATA) && !in_req_type)
    else $error("payload beat outside payload phase");

  // payload countdown stays within the frame
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == krd_pkg::PH_DATA)
      |-> (bytes_left_r != 16'd0) && (bytes_left_r <= frame_length_r))
    else $error("payload count out of range");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for kernel_response_deframer: framed byte stream against a cycle-free predictor.
`timescale 1ns / 1ps

module testbench;
  import krd_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BEATS_PER_SETTING = 180;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_response_id;
  logic [15:0] out_payload_length;
  logic [2:0]  out_error_code;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  kernel_response_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_response_id    (out_response_id),
    .out_payload_length (out_payload_length),
    .out_error_code     (out_error_code),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Deframer state as the testbench expects it
  phase_t      rx_phase  = PH_PRE1;
  logic [7:0]  rx_sum    = 8'h00;
  logic [15:0] rx_len    = 16'h0000;
  logic [15:0] rx_left   = 16'h0000;
  logic [7:0]  rx_id     = 8'h00;
  logic [15:0] max_limit = MAX_PAYLOAD_RST;

  result_t results_due[$];
  int      fail_count  = 0;
  int      beats_sent  = 0;
  int      burst_left  = 0;
  int      idle_cycles = 0;

  // Receiver stall pattern state
  int pattern_left  = 0;
  bit pattern_level = 1'b1;
  bit pattern_chop  = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Queue an error result and return to preamble hunting
  function automatic void flag_frame_error(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.error_code = code;
    rx_phase = PH_PRE1;
    results_due.push_back(r);
  endfunction

  // Advance the expected parser state by one accepted beat
  function automatic void predict_deframe(input logic timeout, input logic [7:0] b);
    result_t r;
    r = '0;
    if (timeout) begin
      flag_frame_error(ERR_TIMEOUT);
      return;
    end
    case (rx_phase)
      PH_PRE2: begin
        if (b != PREAMBLE2) begin
          flag_frame_error(ERR_PRE2);
        end else begin
          rx_sum = rx_sum + b;
          rx_phase = PH_LENH;
        end
      end
      PH_LENH: begin
        rx_len = {b, 8'h00};
        rx_sum = rx_sum + b;
        rx_phase = PH_LENL;
      end
      PH_LENL: begin
        rx_len = rx_len | {8'h00, b};
        rx_sum = rx_sum + b;
        if (rx_len == 16'd0) begin
          flag_frame_error(ERR_ZEROLEN);
        end else begin
          rx_len = rx_len - 16'd1;
          rx_phase = PH_ID;
        end
      end
      PH_ID: begin
        rx_id = b;
        rx_sum = rx_sum + b;
        if (rx_len > max_limit) begin
          flag_frame_error(ERR_BIG);
        end else begin
          rx_left = rx_len;
          rx_phase = (rx_left == 16'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        rx_sum = rx_sum + b;
        rx_left = rx_left - 16'd1;
        if (rx_left == 16'd0) rx_phase = PH_SUM;
        r.kind = KIND_DATA;
        r.payload_byte = b;
        results_due.push_back(r);
      end
      PH_SUM: begin
        if (b != rx_sum) begin
          flag_frame_error(ERR_SUM);
        end else begin
          rx_phase = PH_PRE1;
          r.kind = KIND_OK;
          r.response_id = rx_id;
          r.payload_length = rx_len;
          results_due.push_back(r);
        end
      end
      default: begin
        // hunting, and any unused phase code
        rx_phase = PH_PRE1;
        if (b != PREAMBLE1) begin
          flag_frame_error(ERR_PRE1);
        end else begin
          rx_sum = PREAMBLE1;
          rx_phase = PH_PRE2;
        end
      end
    endcase
  endfunction

  // Drive one beat, inserting a random gap between bursts; return at its accept edge
  task automatic send_beat(input logic timeout, input logic [7:0] b);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= timeout;
    in_rx_byte  <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    beats_sent++;
    predict_deframe(timeout, b);
  endtask

  // Hold the sender until every expected result has drained
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_limit = value;
  endtask

  // Build a frame with the given length field; flip the checksum or cut it short
  // with a timeout after cut_at bytes (negative: no cut)
  task automatic send_frame(input logic [15:0] len_field, input logic [7:0] id,
                            input logic [7:0] sum_flip, input int cut_at);
    logic [7:0]  frame_q[$];
    logic [7:0]  sum;
    int unsigned n;
    int unsigned n_built;
    int          k;
    sum = 8'h00;
    n_built = 0;
    frame_q = '{PREAMBLE1, PREAMBLE2, len_field[15:8], len_field[7:0]};
    if (len_field != 16'd0) begin
      frame_q.push_back(id);
      n = len_field - 16'd1;
      if (n <= max_limit) begin
        while (n_built < n && (cut_at < 0 || frame_q.size() < cut_at)) begin
          frame_q.push_back(8'($urandom));
          n_built++;
        end
        if (n_built == n) begin
          foreach (frame_q[i]) sum = sum + frame_q[i];
          frame_q.push_back(sum ^ sum_flip);
        end
      end
    end
    for (k = 0; k < frame_q.size() && (cut_at < 0 || k < cut_at); k++)
      send_beat(1'b0, frame_q[k]);
    if (cut_at >= 0) send_beat(1'b1, 8'($urandom));
  endtask

  // Pick a payload size, mostly small, and an occasional flaw
  task automatic send_random_frame();
    int unsigned n;
    int          pick;
    int          cut;
    logic [7:0]  flip;
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      n = $urandom_range(0, 8);
    end else if (pick < 16) begin
      if (max_limit <= 40) begin
        n = max_limit + $urandom_range(0, 2);
        if (n > 0) n = n - 1;
      end else begin
        n = $urandom_range(9, 40);
      end
    end else if (pick == 16) begin
      n = $urandom_range(9, 300);
    end else if (pick == 17) begin
      n = $urandom_range(301, 65534);
    end else begin
      n = $urandom_range(0, 3);
    end
    cut = -1;
    flip = 8'h00;
    case ($urandom_range(0, 9))
      0: flip = 8'($urandom_range(1, 255));
      1: cut = $urandom_range(0, 6 + ((n < 20) ? n : 20));
      default: ;
    endcase
    // keep long frames short on the wire
    if (n > 300 && n <= max_limit && cut < 0) cut = $urandom_range(5, 30);
    send_frame(16'(n + 1), 8'($urandom), flip, cut);
  endtask

  task automatic test_hunting_errors();
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, PREAMBLE1);
    send_beat(1'b0, 8'hFF);
  endtask

  task automatic test_header_errors();
    send_frame(16'd0, 8'h00, 8'h00, -1);
    send_frame(16'hFFFF, 8'h00, 8'h00, -1);
  endtask

  task automatic test_short_frames();
    send_frame(16'd1, 8'hFF, 8'h00, -1);
    send_frame(16'd2, 8'h5A, 8'h01, -1);
  endtask

  // Random traffic under a series of payload limits, extremes included
  task automatic test_register_sweep();
    logic [15:0] settings[6];
    int          target;
    logic [7:0]  b;
    settings = '{MAX_PAYLOAD_RST, 16'd0, 16'hFFFF, 16'd1,
                 16'($urandom_range(2, 40)), 16'($urandom)};
    foreach (settings[s]) begin
      write_max_payload(settings[s]);
      target = beats_sent + BEATS_PER_SETTING;
      while (beats_sent < target) begin
        case ($urandom_range(0, 19))
          0: send_frame(16'd0, 8'($urandom), 8'h00, -1);
          1: begin
            repeat ($urandom_range(1, 4)) begin
              b = $urandom_range(0, 1) ? PREAMBLE1 : 8'($urandom);
              send_beat($urandom_range(0, 3) == 0, b);
            end
          end
          2: begin
            b = 8'($urandom);
            if (b == PREAMBLE2) b = 8'h00;
            send_beat(1'b0, PREAMBLE1);
            send_beat(1'b0, b);
          end
          default: send_random_frame();
        endcase
        if ($urandom_range(0, 11) == 0) settle_idle();
      end
    end
  endtask

  // Stall the receiver in runs: open stretches, long stalls, and chopped stretches
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          pattern_level = 1'b1;
          pattern_chop  = 1'b0;
          pattern_left  = $urandom_range(10, 60);
        end
        2: begin
          pattern_level = 1'b0;
          pattern_chop  = 1'b0;
          pattern_left  = $urandom_range(1, 40);
        end
        default: begin
          pattern_chop = 1'b1;
          pattern_left = $urandom_range(5, 30);
        end
      endcase
    end
    pattern_left--;
    out_ready <= pattern_chop ? 1'($urandom_range(0, 1)) : pattern_level;
  end

  // Compare each result beat with the oldest expectation
  always @(negedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_payload_byte, out_response_id, out_payload_length,
             out_error_code};
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind=%0d byte=%02h id=%02h len=%0d err=%0d",
                   got.kind, got.payload_byte, got.response_id,
                   got.payload_length, got.error_code);
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.response_id !== want.response_id ||
            got.payload_length !== want.payload_length ||
            got.error_code !== want.error_code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected kind=%0d byte=%02h id=%02h len=%0d err=%0d, %s",
                     want.kind, want.payload_byte, want.response_id,
                     want.payload_length, want.error_code,
                     $sformatf("got kind=%0d byte=%02h id=%02h len=%0d err=%0d",
                               got.kind, got.payload_byte, got.response_id,
                               got.payload_length, got.error_code));
        end
      end
    end
  end

  // End the run when no beat moves on either channel for too long
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hunting_errors();
    test_header_errors();
    test_short_frames();
    test_register_sweep();
    settle_idle();
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[kernel_response_deframer.f]
sv/krd_pkg.sv
sv/kernel_response_deframer.sv
tb/testbench.sv
